### rtl/sbrp_pkg.sv
package sbrp_pkg;

  localparam int SCALE_SHIFT = 8;

  localparam int SPEED_W  = 24;
  localparam int FMT_W    = 4;
  localparam int RATE_W   = 14;
  localparam int BITS_W   = 4;
  localparam int PERIOD_W = 20;
  localparam int CREDIT_W = 32;
  localparam int QUOTA_W  = 24;

  // frame is at least 7 bits, so the scaled rate stays below 2^(speed + shift - 2)
  localparam int SCALED_W = SPEED_W + SCALE_SHIFT - 2;
  localparam int DVD_W    = SCALED_W + PERIOD_W;
  localparam int CNT_W    = $clog2(DVD_W + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic [1:0] action_t;
  localparam action_t ACT_APPLY = 2'd0;
  localparam action_t ACT_TICK  = 2'd1;
  localparam action_t ACT_OFFER = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FLOW_ENABLE  = 3'd0;
  localparam cfg_idx_t REG_LOCAL_FMT    = 3'd1;
  localparam cfg_idx_t REG_REMOTE_FMT   = 3'd2;
  localparam cfg_idx_t REG_LOCAL_SPEED  = 3'd3;
  localparam cfg_idx_t REG_REMOTE_SPEED = 3'd4;
  localparam cfg_idx_t REG_TICK_RATE    = 3'd5;

  function automatic logic [BITS_W-1:0] frame_bits(input logic [FMT_W-1:0] fmt);
    return 4'd7 + {2'b00, fmt[1:0]} + {3'b000, fmt[2]} + {3'b000, fmt[3]};
  endfunction

endpackage

### rtl/sbrp_if.sv
interface sbrp_in_if import sbrp_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  logic [7:0] char_byte;
  logic    receiver_room;

  modport source (output valid, action, char_byte, receiver_room, input ready);
  modport sink (input valid, action, char_byte, receiver_room, output ready);
endinterface

interface sbrp_out_if;
  logic       valid;
  logic       ready;
  logic       forwarded;
  logic [7:0] out_byte;
  logic       quota_blocked;

  modport source (output valid, forwarded, out_byte, quota_blocked, input ready);
  modport sink (input valid, forwarded, out_byte, quota_blocked, output ready);
endinterface

### rtl/serial_baud_rate_pacer.sv
// Paces characters on one direction of a virtual serial link. Tick and character-offer
// beats need no divider, and a new beat is taken every cycle while the result
// register drains. An apply-settings beat runs three restoring divisions on one shared
// one-bit-per-cycle divider (DVD_W steps plus one each) and one multiply, and input
// ready stays low until it returns to idle. When flow is disabled or the speed is zero,
// apply-settings skips the divider and its result is registered straight from idle.
module serial_baud_rate_pacer import sbrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  sbrp_in_if.sink               in_ch,
  sbrp_out_if.source            out_ch,
  input  logic                  wr_en,
  input  cfg_idx_t              wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  localparam logic [2:0] S_IDLE        = 3'd0;
  localparam logic [2:0] S_DIV_SCALED  = 3'd1;
  localparam logic [2:0] S_DIV_PERIOD  = 3'd2;
  localparam logic [2:0] S_MUL         = 3'd3;
  localparam logic [2:0] S_DIV_CREDITS = 3'd4;

  logic [2:0]             state;

  logic                   flow_enable;
  logic [FMT_W-1:0]       local_fmt;
  logic [FMT_W-1:0]       remote_fmt;
  logic [SPEED_W-1:0]     local_speed;
  logic [SPEED_W-1:0]     remote_speed;
  logic [RATE_W-1:0]      tick_rate;

  logic [PERIOD_W-1:0]    tick_period;
  logic [PERIOD_W-1:0]    period_countdown;
  logic [CREDIT_W-1:0]    credits_per_period;
  logic [SCALE_SHIFT-1:0] fraction_residue;
  logic [QUOTA_W-1:0]     char_quota;

  logic [PERIOD_W-1:0]    period_r;
  logic [DVD_W-1:0]       dvd;
  logic [SCALED_W-1:0]    dvs;
  logic [SCALED_W-1:0]    rem;
  logic [CNT_W-1:0]       cnt;

  logic                   out_valid;
  logic                   fwd;
  logic [7:0]             obyte;
  logic                   blocked;

  logic                   in_accept;
  logic [BITS_W-1:0]      lbits;
  logic [BITS_W-1:0]      rbits;
  logic [BITS_W-1:0]      bits;
  logic [SPEED_W-1:0]     speed;
  logic [RATE_W-1:0]      hz;
  logic [SCALED_W:0]      rem_shift;
  logic                   ge;
  logic [SCALED_W:0]      diff;
  logic [SCALED_W-1:0]    scaled;
  logic [PERIOD_W-1:0]    period_q;
  logic [DVD_W-1:0]       product;
  logic [CREDIT_W:0]      acc;
  logic [CREDIT_W:0]      qfull;

  assign in_ch.ready     = (state == S_IDLE) && (!out_valid || out_ch.ready);
  assign in_accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.forwarded     = fwd;
  assign out_ch.out_byte      = obyte;
  assign out_ch.quota_blocked = blocked;

  assign lbits = frame_bits(local_fmt);
  assign rbits = frame_bits(remote_fmt);
  assign bits  = (lbits > rbits) ? lbits : rbits;
  assign speed = (local_speed < remote_speed) ? local_speed : remote_speed;
  assign hz    = (tick_rate == '0) ? RATE_W'(1) : tick_rate;

  // shared divider step
  assign rem_shift = {rem, dvd[DVD_W-1]};
  assign ge        = rem_shift >= {1'b0, dvs};
  assign diff      = rem_shift - {1'b0, dvs};

  assign scaled   = (dvd[SCALED_W-1:0] == '0) ? SCALED_W'(1) : dvd[SCALED_W-1:0];
  assign period_q = (|dvd[DVD_W-1:PERIOD_W]) ? '1 :
                    (dvd[PERIOD_W-1:0] == '0) ? PERIOD_W'(1) : dvd[PERIOD_W-1:0];
  assign product  = {{PERIOD_W{1'b0}}, dvs} * {{SCALED_W{1'b0}}, period_r};

  assign acc   = {1'b0, credits_per_period}
               + {{(CREDIT_W + 1 - SCALE_SHIFT){1'b0}}, fraction_residue};
  assign qfull = acc >> SCALE_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      flow_enable        <= 1'b0;
      local_fmt          <= FMT_W'(3);
      remote_fmt         <= FMT_W'(3);
      local_speed        <= SPEED_W'(9600);
      remote_speed       <= SPEED_W'(9600);
      tick_rate          <= RATE_W'(1000);
      tick_period        <= '0;
      period_countdown   <= '0;
      credits_per_period <= '0;
      fraction_residue   <= '0;
      char_quota         <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_FLOW_ENABLE:  flow_enable  <= wr_data[0];
          REG_LOCAL_FMT:    local_fmt    <= wr_data[FMT_W-1:0];
          REG_REMOTE_FMT:   remote_fmt   <= wr_data[FMT_W-1:0];
          REG_LOCAL_SPEED:  local_speed  <= wr_data[SPEED_W-1:0];
          REG_REMOTE_SPEED: remote_speed <= wr_data[SPEED_W-1:0];
          REG_TICK_RATE:    tick_rate    <= wr_data[RATE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            fwd     <= 1'b0;
            obyte   <= '0;
            blocked <= 1'b0;
            case (in_ch.action)
              ACT_APPLY: begin
                if (!flow_enable || speed == '0) begin
                  tick_period <= '0;
                  out_valid   <= 1'b1;
                end else begin
                  dvd   <= {{(DVD_W - SPEED_W - SCALE_SHIFT){1'b0}}, speed,
                            {SCALE_SHIFT{1'b0}}};
                  dvs   <= {{(SCALED_W - BITS_W){1'b0}}, bits};
                  rem   <= '0;
                  cnt   <= CNT_W'(DVD_W);
                  state <= S_DIV_SCALED;
                end
              end
              ACT_TICK: begin
                out_valid <= 1'b1;
                if (tick_period != '0) begin
                  if (period_countdown > PERIOD_W'(1)) begin
                    period_countdown <= period_countdown - PERIOD_W'(1);
                  end else begin
                    period_countdown <= tick_period;
                    char_quota       <= (|qfull[CREDIT_W:QUOTA_W]) ? '1
                                                                  : qfull[QUOTA_W-1:0];
                    fraction_residue <= acc[SCALE_SHIFT-1:0];
                  end
                end
              end
              ACT_OFFER: begin
                out_valid <= 1'b1;
                if (in_ch.receiver_room) begin
                  if (tick_period != '0 && char_quota == '0) begin
                    blocked <= 1'b1;
                  end else begin
                    if (char_quota != '0) begin
                      char_quota <= char_quota - QUOTA_W'(1);
                    end
                    fwd   <= 1'b1;
                    obyte <= in_ch.char_byte;
                  end
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_DIV_SCALED, S_DIV_PERIOD, S_DIV_CREDITS: begin
          if (cnt != '0) begin
            rem <= ge ? diff[SCALED_W-1:0] : rem_shift[SCALED_W-1:0];
            dvd <= {dvd[DVD_W-2:0], ge};
            cnt <= cnt - CNT_W'(1);
          end else if (state == S_DIV_SCALED) begin
            dvd   <= {{(DVD_W - RATE_W - SCALE_SHIFT){1'b0}}, hz, {SCALE_SHIFT{1'b0}}};
            dvs   <= scaled;
            rem   <= '0;
            cnt   <= CNT_W'(DVD_W);
            state <= S_DIV_PERIOD;
          end else if (state == S_DIV_PERIOD) begin
            period_r <= period_q;
            state    <= S_MUL;
          end else begin
            credits_per_period <= (|dvd[DVD_W-1:CREDIT_W]) ? '1 : dvd[CREDIT_W-1:0];
            tick_period        <= period_r;
            period_countdown   <= period_r;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        S_MUL: begin
          dvd   <= product;
          dvs   <= {{(SCALED_W - RATE_W){1'b0}}, hz};
          rem   <= '0;
          cnt   <= CNT_W'(DVD_W);
          state <= S_DIV_CREDITS;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### verif/tb_serial_baud_rate_pacer.sv
module tb_serial_baud_rate_pacer import sbrp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam action_t ACT_UNUSED = 2'd3;
  localparam int RUN_LIMIT = 500000;
  localparam int HOLD_AT = 110;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    action_t    action;
    logic [7:0] char_byte;
    logic       receiver_room;
  } link_item_t;

  typedef struct packed {
    logic       forwarded;
    logic [7:0] out_byte;
    logic       quota_blocked;
  } link_result_t;

  logic clk;
  logic rst;
  logic wr_en;
  cfg_idx_t wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  sbrp_in_if in_ch ();
  sbrp_out_if out_ch ();

  serial_baud_rate_pacer u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // shadow of the configuration registers
  logic              cfg_flow   = 1'b0;
  logic [FMT_W-1:0]  cfg_lfmt   = 4'd3;
  logic [FMT_W-1:0]  cfg_rfmt   = 4'd3;
  logic [SPEED_W-1:0] cfg_lspeed = 24'd9600;
  logic [SPEED_W-1:0] cfg_rspeed = 24'd9600;
  logic [RATE_W-1:0] cfg_rate   = 14'd1000;

  // pacing state
  logic [PERIOD_W-1:0]    pace_period    = '0;
  logic [PERIOD_W-1:0]    pace_countdown = '0;
  logic [CREDIT_W-1:0]    pace_credits   = '0;
  logic [SCALE_SHIFT-1:0] pace_residue   = '0;
  logic [QUOTA_W-1:0]     pace_quota     = '0;

  link_item_t   pending_items[$];
  link_result_t expected_results[$];

  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned beats_taken = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned n_apply = 0, n_tick = 0, n_offer = 0, n_fwd = 0, n_blocked = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 0;
  bit          no_gaps = 0;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic link_result_t pace_step(link_item_t it);
    link_result_t res;
    bit [63:0] nbits, rbits, speed, scaled, period, credits, hz, acc;
    res = '0;
    case (it.action)
      ACT_APPLY: begin
        if (!cfg_flow) begin
          pace_period = '0;
        end else begin
          nbits = 7 + cfg_lfmt[1:0] + cfg_lfmt[2] + cfg_lfmt[3];
          rbits = 7 + cfg_rfmt[1:0] + cfg_rfmt[2] + cfg_rfmt[3];
          if (rbits > nbits) nbits = rbits;
          speed = (cfg_lspeed < cfg_rspeed) ? cfg_lspeed : cfg_rspeed;
          if (speed == 0) begin
            pace_period = '0;
          end else begin
            hz = (cfg_rate == 0) ? 64'd1 : 64'(cfg_rate);
            scaled = (speed << SCALE_SHIFT) / nbits;
            if (scaled == 0) scaled = 1;
            period = (hz << SCALE_SHIFT) / scaled;
            if (period == 0) period = 1;
            if (period > {PERIOD_W{1'b1}}) period = {PERIOD_W{1'b1}};
            credits = (scaled * period) / hz;
            if (credits > {CREDIT_W{1'b1}}) credits = {CREDIT_W{1'b1}};
            pace_period = period[PERIOD_W-1:0];
            pace_countdown = period[PERIOD_W-1:0];
            pace_credits = credits[CREDIT_W-1:0];
          end
        end
      end
      ACT_TICK: begin
        if (pace_period != 0) begin
          if (pace_countdown > 1) begin
            pace_countdown = pace_countdown - PERIOD_W'(1);
          end else begin
            pace_countdown = pace_period;
            acc = pace_residue + pace_credits;
            pace_residue = acc[SCALE_SHIFT-1:0];
            acc = acc >> SCALE_SHIFT;
            if (acc > {QUOTA_W{1'b1}}) acc = {QUOTA_W{1'b1}};
            pace_quota = acc[QUOTA_W-1:0];
          end
        end
      end
      ACT_OFFER: begin
        if (it.receiver_room) begin
          if (pace_period != 0 && pace_quota == 0) begin
            res.quota_blocked = 1'b1;
          end else begin
            if (pace_quota != 0) pace_quota = pace_quota - QUOTA_W'(1);
            res.forwarded = 1'b1;
            res.out_byte = it.char_byte;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // sender
  always @(posedge clk) begin
    link_item_t   nxt;
    link_item_t   took;
    link_result_t res;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= ACT_TICK;
      in_ch.char_byte <= 8'h00;
      in_ch.receiver_room <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        took = '{action: in_ch.action, char_byte: in_ch.char_byte,
                 receiver_room: in_ch.receiver_room};
        res = pace_step(took);
        expected_results.push_back(res);
        beats_taken <= beats_taken + 1;
        case (took.action)
          ACT_APPLY: n_apply++;
          ACT_TICK:  n_tick++;
          ACT_OFFER: n_offer++;
          default: ;
        endcase
        if (res.forwarded) n_fwd++;
        if (res.quota_blocked) n_blocked++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_ch.action <= nxt.action;
          in_ch.char_byte <= nxt.char_byte;
          in_ch.receiver_room <= nxt.receiver_room;
          in_ch.valid <= 1'b1;
          send_gap <= gap_len();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off once the run is under way
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && beats_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready) recv_gap <= gap_len();
    end
  end

  // result checker
  always @(posedge clk) begin
    link_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat fwd=%0b byte=%02h blocked=%0b",
                                  out_ch.forwarded, out_ch.out_byte, out_ch.quota_blocked));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.forwarded !== want.forwarded)
          report_mismatch($sformatf("forwarded %0b, expected %0b",
                                    out_ch.forwarded, want.forwarded));
        if (out_ch.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_ch.out_byte, want.out_byte));
        if (out_ch.quota_blocked !== want.quota_blocked)
          report_mismatch($sformatf("quota_blocked %0b, expected %0b",
                                    out_ch.quota_blocked, want.quota_blocked));
      end
    end
  end

  task automatic queue_item(action_t a, logic [7:0] b, logic room);
    pending_items.push_back('{action: a, char_byte: b, receiver_room: room});
    items_queued++;
  endtask

  task automatic queue_random(int n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 3)
        queue_item(ACT_APPLY, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 5)
        queue_item(ACT_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 50)
        queue_item(ACT_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else
        queue_item(ACT_OFFER, 8'($urandom_range(255)), 1'($urandom_range(9) != 0));
    end
  endtask

  task automatic wait_idle();
    while (results_seen != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_FLOW_ENABLE:  cfg_flow = val[0];
      REG_LOCAL_FMT:    cfg_lfmt = val[FMT_W-1:0];
      REG_REMOTE_FMT:   cfg_rfmt = val[FMT_W-1:0];
      REG_LOCAL_SPEED:  cfg_lspeed = val[SPEED_W-1:0];
      REG_REMOTE_SPEED: cfg_rspeed = val[SPEED_W-1:0];
      REG_TICK_RATE:    cfg_rate = val[RATE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic program_link(int unsigned flow, int unsigned lfmt, int unsigned rfmt,
                              int unsigned lspd, int unsigned rspd, int unsigned rate);
    write_reg(REG_FLOW_ENABLE, flow);
    write_reg(REG_LOCAL_FMT, lfmt);
    write_reg(REG_REMOTE_FMT, rfmt);
    write_reg(REG_LOCAL_SPEED, lspd);
    write_reg(REG_REMOTE_SPEED, rspd);
    write_reg(REG_TICK_RATE, rate);
  endtask

  task automatic run_phase(int unsigned flow, int unsigned lfmt, int unsigned rfmt,
                           int unsigned lspd, int unsigned rspd, int unsigned rate,
                           int n, bit steady);
    program_link(flow, lfmt, rfmt, lspd, rspd, rate);
    no_gaps = steady;
    queue_item(ACT_APPLY, 8'h00, 1'b1);
    queue_random(n);
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_FLOW_ENABLE;
    wr_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // pacing off after reset: everything with room goes through
    queue_item(ACT_OFFER, 8'h00, 1'b1);
    queue_item(ACT_OFFER, 8'hFF, 1'b1);
    queue_item(ACT_OFFER, 8'h5A, 1'b0);
    queue_item(ACT_TICK, 8'h00, 1'b1);
    queue_item(ACT_UNUSED, 8'hFF, 1'b1);
    queue_item(ACT_APPLY, 8'h00, 1'b1);
    queue_item(ACT_OFFER, 8'hA5, 1'b1);
    wait_idle();

    // pacing on at the reset speeds: quota builds up over ticks
    write_reg(REG_FLOW_ENABLE, 1);
    queue_item(ACT_APPLY, 8'h00, 1'b1);
    queue_item(ACT_OFFER, 8'h11, 1'b1);
    queue_item(ACT_TICK, 8'h00, 1'b0);
    queue_item(ACT_TICK, 8'h00, 1'b0);
    queue_item(ACT_OFFER, 8'h22, 1'b1);
    queue_item(ACT_OFFER, 8'h33, 1'b1);
    queue_item(ACT_OFFER, 8'h44, 1'b0);
    queue_item(ACT_TICK, 8'h00, 1'b1);
    queue_item(ACT_TICK, 8'h00, 1'b1);
    wait_idle();

    // zero speed turns pacing off
    write_reg(REG_LOCAL_SPEED, 0);
    queue_item(ACT_APPLY, 8'h00, 1'b1);
    queue_item(ACT_OFFER, 8'h80, 1'b1);
    queue_item(ACT_TICK, 8'h00, 1'b1);
    wait_idle();

    // zero tick rate, top speeds, shortest frames
    write_reg(REG_TICK_RATE, 0);
    write_reg(REG_LOCAL_SPEED, 24'hFFFFFF);
    write_reg(REG_REMOTE_SPEED, 24'hFFFFFF);
    write_reg(REG_LOCAL_FMT, 0);
    write_reg(REG_REMOTE_FMT, 0);
    queue_item(ACT_APPLY, 8'h00, 1'b1);
    queue_item(ACT_TICK, 8'h00, 1'b1);
    queue_item(ACT_OFFER, 8'h01, 1'b1);
    queue_item(ACT_OFFER, 8'hFE, 1'b1);
    wait_idle();

    run_phase(1, 15, 0, 115200, 57600, 100, 60, 0);
    run_phase(1, 4, 9, 2400, 4800, 2000, 80, 0);
    run_phase(0, 3, 3, 9600, 9600, 1000, 40, 0);
    run_phase(1, 0, 15, 24'hFFFFFF, 24'hFFFFFF, 10000, 60, 1);
    run_phase(1, 0, 0, 1, 24'hFFFFFF, 1, 60, 0);
    run_phase(1, 3, 3, 9600, 9600, 1000, 80, 0);

    while (results_seen != items_queued) @(posedge clk);
    repeat (200) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("ran %0d beats: %0d apply-settings, %0d ticks, %0d character offers",
             beats_taken, n_apply, n_tick, n_offer);
    $display("offers forwarded %0d, held for quota %0d, mismatches %0d",
             n_fwd, n_blocked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
